/* rtl/core/shape_span_rasterizer_top_assert.svh */
// assertion macros shared by the checker of the shape span rasterizer
`ifndef SHAPE_SPAN_RASTERIZER_TOP_ASSERT_SVH
`define SHAPE_SPAN_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define SSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssr check failed");

// next-cycle implication, sampled on clk, quiet while in reset
`define SSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssr check failed");

`endif

/* rtl/core/ssr_pkg.sv */
// shared types, constants and codes of the shape span rasterizer
`default_nettype none

package ssr_pkg;

    // canvas store geometry
    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W       = ROW_W + COL_W;
    localparam int CANVAS_DEPTH = 1 << ADDR_W;

    // field widths
    localparam int USED_W  = 7;
    localparam int HGT_W   = 7;
    localparam int COORD_W = 12;
    localparam int SPAN_W  = 14;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 13;
    localparam int FUNC_W  = 3;

    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

    // register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [USED_W-1:0]    ROWS_RESET = 7'd64;
    localparam logic [USED_W-1:0]    COLS_RESET = 7'd64;

    // register values above the store size are capped
    localparam logic [USED_W-1:0] ROWS_CAP =
        (MAX_ROWS > 127) ? 7'd127 : USED_W'(MAX_ROWS);
    localparam logic [USED_W-1:0] COLS_CAP =
        (MAX_COLS > 127) ? 7'd127 : USED_W'(MAX_COLS);

    // command codes
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PIXEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RECT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UP      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DOWN    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DIAMOND = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd6;

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FILL,
        KIND_READ
    } kind_t;

    typedef enum logic [1:0] {
        SHAPE_RECT,
        SHAPE_UP,
        SHAPE_DOWN,
        SHAPE_DIAMOND
    } shape_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic [HGT_W-1:0]          shape_height;
        logic [HGT_W-1:0]          shape_width;
        logic [CHAR_W-1:0]         brush_char;
    } in_t;

    typedef struct packed {
        logic              in_bounds;
        logic [CHAR_W-1:0] read_char;
        logic [CNT_W-1:0]  pixels_written;
    } out_t;

    // classified command as held in the queue
    typedef struct packed {
        kind_t                     kind;
        shape_t                    shape;
        logic                      inb;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic [HGT_W-1:0]          height;
        logic [HGT_W-1:0]          width;
        logic [CHAR_W-1:0]         brush;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ssr_front.sv */
// front end: turns input beats into queued fill, read or no-op commands
`default_nettype none

module ssr_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire ssr_pkg::in_t                in_data,
    input  wire logic [ssr_pkg::USED_W-1:0]  rows_used,
    input  wire logic [ssr_pkg::USED_W-1:0]  cols_used,
    input  wire ssr_pkg::fifo_stat_t         q_stat,
    input  wire ssr_pkg::back_stat_t         b_stat,
    output logic                             push,
    output ssr_pkg::cmd_t                    push_data
);

    logic signed [ssr_pkg::COORD_W:0] x_ext;
    logic signed [ssr_pkg::COORD_W:0] y_ext;
    logic signed [ssr_pkg::COORD_W:0] rows_ext;
    logic signed [ssr_pkg::COORD_W:0] cols_ext;
    logic                             in_area;

    assign in_stall = q_stat.full || b_stat.clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        x_ext    = {in_data.x_pos[ssr_pkg::COORD_W-1], in_data.x_pos};
        y_ext    = {in_data.y_pos[ssr_pkg::COORD_W-1], in_data.y_pos};
        rows_ext = {{(ssr_pkg::COORD_W + 1 - ssr_pkg::USED_W){1'b0}}, rows_used};
        cols_ext = {{(ssr_pkg::COORD_W + 1 - ssr_pkg::USED_W){1'b0}}, cols_used};
        in_area  = (x_ext >= 0) && (y_ext >= 0) && (x_ext < cols_ext) && (y_ext < rows_ext);

        push_data.kind   = ssr_pkg::KIND_NONE;
        push_data.shape  = ssr_pkg::SHAPE_RECT;
        push_data.inb    = 1'b0;
        push_data.x_pos  = in_data.x_pos;
        push_data.y_pos  = in_data.y_pos;
        push_data.height = in_data.shape_height;
        push_data.width  = in_data.shape_width;
        push_data.brush  = in_data.brush_char;

        case (in_data.func)
            ssr_pkg::FN_CLEAR:
            begin
                // whole area in use as one rectangle of dots
                push_data.kind   = ssr_pkg::KIND_FILL;
                push_data.x_pos  = '0;
                push_data.y_pos  = '0;
                push_data.height = rows_used;
                push_data.width  = cols_used;
                push_data.brush  = ssr_pkg::DOT_CHAR;
            end
            ssr_pkg::FN_PIXEL:
            begin
                if (in_area)
                begin
                    push_data.kind   = ssr_pkg::KIND_FILL;
                    push_data.inb    = 1'b1;
                    push_data.height = ssr_pkg::HGT_W'(1);
                    push_data.width  = ssr_pkg::HGT_W'(1);
                end
            end
            ssr_pkg::FN_RECT:
            begin
                push_data.kind = ssr_pkg::KIND_FILL;
                if (in_data.shape_width == '0)
                begin
                    push_data.height = '0;
                end
            end
            ssr_pkg::FN_UP:
            begin
                push_data.kind  = ssr_pkg::KIND_FILL;
                push_data.shape = ssr_pkg::SHAPE_UP;
            end
            ssr_pkg::FN_DOWN:
            begin
                push_data.kind  = ssr_pkg::KIND_FILL;
                push_data.shape = ssr_pkg::SHAPE_DOWN;
            end
            ssr_pkg::FN_DIAMOND:
            begin
                push_data.kind  = ssr_pkg::KIND_FILL;
                push_data.shape = ssr_pkg::SHAPE_DIAMOND;
            end
            ssr_pkg::FN_READ:
            begin
                if (in_area)
                begin
                    push_data.kind = ssr_pkg::KIND_READ;
                    push_data.inb  = 1'b1;
                end
            end
            default:
            begin
                push_data.kind = ssr_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ssr_fifo.sv */
// short command queue between front and back
`default_nettype none

module ssr_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ssr_pkg::cmd_t       push_data,
    input  wire logic                pop,
    output ssr_pkg::cmd_t            head,
    output ssr_pkg::fifo_stat_t      stat
);

    ssr_pkg::cmd_t                       entry_reg [ssr_pkg::FIFO_DEPTH];
    logic [ssr_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [ssr_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
    logic [ssr_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [ssr_pkg::FIFO_PTR_W-1:0]      rd_ptr_next;
    logic [ssr_pkg::FIFO_PTR_W:0]        fill_reg;
    logic [ssr_pkg::FIFO_PTR_W:0]        fill_next;
    logic                                do_push;
    logic                                do_pop;

    assign stat.full  = (fill_reg == (ssr_pkg::FIFO_PTR_W + 1)'(ssr_pkg::FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ssr_back.sv */
// back end: canvas store, span walker and result register
`default_nettype none

module ssr_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ssr_pkg::USED_W-1:0]  rows_used,
    input  wire logic [ssr_pkg::USED_W-1:0]  cols_used,
    input  wire ssr_pkg::cmd_t               q_head,
    input  wire ssr_pkg::fifo_stat_t         q_stat,
    output logic                             q_pop,
    output ssr_pkg::back_stat_t              b_stat,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output ssr_pkg::out_t                    out_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_CLIP,
        ST_SPAN,
        ST_READ,
        ST_DONE
    } state_t;

    localparam int SW = ssr_pkg::SPAN_W;

    // canvas store
    logic [ssr_pkg::CHAR_W-1:0] canvas_mem [ssr_pkg::CANVAS_DEPTH];
    logic [ssr_pkg::CHAR_W-1:0] rd_data_reg;
    logic [ssr_pkg::ADDR_W-1:0] rd_addr;
    logic                       mem_we;
    logic [ssr_pkg::ADDR_W-1:0] mem_waddr;
    logic [ssr_pkg::CHAR_W-1:0] mem_wdata;

    state_t                     state_reg, state_next;
    ssr_pkg::cmd_t              cmd_reg, cmd_next;
    logic [ssr_pkg::HGT_W-1:0]  row_idx_reg, row_idx_next;
    logic signed [SW-1:0]       span_row_reg, span_row_next;
    logic signed [SW-1:0]       span_left_reg, span_left_next;
    logic signed [SW-1:0]       span_right_reg, span_right_next;
    logic [ssr_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ssr_pkg::COL_W-1:0]  col_reg, col_next;
    logic [ssr_pkg::COL_W-1:0]  last_col_reg, last_col_next;
    logic [ssr_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ssr_pkg::CHAR_W-1:0] res_char_reg, res_char_next;
    logic [ssr_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                       out_valid_reg, out_valid_next;
    ssr_pkg::out_t              out_data_reg, out_data_next;

    // row geometry
    logic signed [SW-1:0]       xe, ye, idx_s, hw_s, w_s;
    logic signed [SW-1:0]       row_c, left_c, right_c;
    logic [ssr_pkg::HGT_W-1:0]  half2, alt, hw;
    logic [ssr_pkg::HGT_W-1:0]  row_inc;
    logic                       row_last;

    // clipping
    logic signed [SW-1:0]       rows_s, cols_s, cmax, clip_xl, clip_xr;
    logic                       clip_ok;

    assign b_stat.clearing = (state_reg == ST_CLEAR);
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign rd_addr         = {q_head.y_pos[ssr_pkg::ROW_W-1:0], q_head.x_pos[ssr_pkg::COL_W-1:0]};

    always_comb
    begin
        xe    = {{(SW - ssr_pkg::COORD_W){cmd_reg.x_pos[ssr_pkg::COORD_W-1]}}, cmd_reg.x_pos};
        ye    = {{(SW - ssr_pkg::COORD_W){cmd_reg.y_pos[ssr_pkg::COORD_W-1]}}, cmd_reg.y_pos};
        idx_s = {{(SW - ssr_pkg::HGT_W){1'b0}}, row_idx_reg};
        w_s   = {{(SW - ssr_pkg::HGT_W){1'b0}}, cmd_reg.width};
        // diamond half-width is min(i, 2*floor(h/2)-i)
        half2 = {cmd_reg.height[ssr_pkg::HGT_W-1:1], 1'b0};
        alt   = half2 - row_idx_reg;
        hw    = row_idx_reg;
        if ((cmd_reg.shape == ssr_pkg::SHAPE_DIAMOND) && (alt < row_idx_reg))
        begin
            hw = alt;
        end
        hw_s = {{(SW - ssr_pkg::HGT_W){1'b0}}, hw};

        row_c = (cmd_reg.shape == ssr_pkg::SHAPE_DOWN) ? (ye - idx_s) : (ye + idx_s);
        if (cmd_reg.shape == ssr_pkg::SHAPE_RECT)
        begin
            left_c  = xe;
            right_c = xe + w_s - SW'(1);
        end
        else
        begin
            left_c  = xe - hw_s;
            right_c = xe + hw_s;
        end

        rows_s  = {{(SW - ssr_pkg::USED_W){1'b0}}, rows_used};
        cols_s  = {{(SW - ssr_pkg::USED_W){1'b0}}, cols_used};
        cmax    = cols_s - SW'(1);
        clip_xl = (span_left_reg < 0) ? '0 : span_left_reg;
        clip_xr = (span_right_reg > cmax) ? cmax : span_right_reg;
        clip_ok = (span_row_reg >= 0) && (span_row_reg < rows_s) && (clip_xl <= clip_xr);

        row_inc  = row_idx_reg + 1'b1;
        row_last = (row_inc == cmd_reg.height);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        row_idx_next    = row_idx_reg;
        span_row_next   = span_row_reg;
        span_left_next  = span_left_reg;
        span_right_next = span_right_reg;
        cur_row_next    = cur_row_reg;
        col_next        = col_reg;
        last_col_next   = last_col_reg;
        count_next      = count_reg;
        res_char_next   = res_char_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = {cur_row_reg, col_reg};
        mem_wdata       = cmd_reg.brush;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = ssr_pkg::DOT_CHAR;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_head;
                    row_idx_next  = '0;
                    count_next    = '0;
                    res_char_next = '0;
                    case (q_head.kind)
                        ssr_pkg::KIND_FILL:
                        begin
                            state_next = (q_head.height == '0) ? ST_DONE : ST_ROW;
                        end
                        ssr_pkg::KIND_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                span_row_next   = row_c;
                span_left_next  = left_c;
                span_right_next = right_c;
                state_next      = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (clip_ok)
                begin
                    cur_row_next  = span_row_reg[ssr_pkg::ROW_W-1:0];
                    col_next      = clip_xl[ssr_pkg::COL_W-1:0];
                    last_col_next = clip_xr[ssr_pkg::COL_W-1:0];
                    state_next    = ST_SPAN;
                end
                else
                begin
                    row_idx_next = row_inc;
                    state_next   = row_last ? ST_DONE : ST_ROW;
                end
            end
            ST_SPAN:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                col_next   = col_reg + 1'b1;
                if (col_reg == last_col_reg)
                begin
                    row_idx_next = row_inc;
                    state_next   = row_last ? ST_DONE : ST_ROW;
                end
            end
            ST_READ:
            begin
                // store output registered when the command left the queue
                res_char_next = rd_data_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.in_bounds      = cmd_reg.inb;
                    out_data_next.read_char      = res_char_reg;
                    out_data_next.pixels_written = count_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cmd_reg        <= '0;
            row_idx_reg    <= '0;
            span_row_reg   <= '0;
            span_left_reg  <= '0;
            span_right_reg <= '0;
            cur_row_reg    <= '0;
            col_reg        <= '0;
            last_col_reg   <= '0;
            count_reg      <= '0;
            res_char_reg   <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            row_idx_reg    <= row_idx_next;
            span_row_reg   <= span_row_next;
            span_left_reg  <= span_left_next;
            span_right_reg <= span_right_next;
            cur_row_reg    <= cur_row_next;
            col_reg        <= col_next;
            last_col_reg   <= last_col_next;
            count_reg      <= count_next;
            res_char_reg   <= res_char_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            canvas_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= canvas_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/shape_span_rasterizer_top.sv */
// top level of the shape span rasterizer: config registers, front, queue and back
//
// input channel in_valid / in_stall / in_data: one command beat per accepted
//   item (clear, pixel, rectangle, up triangle, down triangle, diamond, read)
// output channel out_valid / out_stall / out_data: exactly one result beat per
//   command, in command order (in-bounds flag, character read, cells written)
// config channel cfg_valid / cfg_ready / cfg_index / cfg_data: index 0 sets the
//   rows in use, index 1 the columns in use, other indexes are dropped;
//   cfg_ready is always high, write only while no command is in flight
// timing: the back end writes one canvas cell per cycle within a span; a fill
//   steps through a row state and a clip state for each row of the shape, a
//   span state for each cell written and then a done state; a read steps
//   through a read state and a done state, a no-op straight to the done state;
//   items are worked one at a time while the two-deep queue keeps taking beats
// reset: control state clears at once, then the back end sweeps all 4096 store
//   cells to '.', one a cycle; in_stall stays high throughout the sweep
// a stalled output beat holds; the back end then waits with its finished
//   result and the queue fills, after which in_stall rises
`default_nettype none

module shape_span_rasterizer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire ssr_pkg::in_t                   in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ssr_pkg::out_t                       out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssr_pkg::USED_W-1:0]     cfg_data
);

    // configuration registers as written
    logic [ssr_pkg::USED_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [ssr_pkg::USED_W-1:0] cols_cfg_reg, cols_cfg_next;
    // area in use, capped to the store size
    logic [ssr_pkg::USED_W-1:0] rows_used;
    logic [ssr_pkg::USED_W-1:0] cols_used;

    // front to queue, queue to back
    logic                   push;
    ssr_pkg::cmd_t          push_data;
    logic                   q_pop;
    ssr_pkg::cmd_t          q_head;
    ssr_pkg::fifo_stat_t    q_stat;
    ssr_pkg::back_stat_t    b_stat;

    assign cfg_ready = 1'b1;

    assign rows_used = (32'(rows_cfg_reg) > ssr_pkg::MAX_ROWS) ? ssr_pkg::ROWS_CAP : rows_cfg_reg;
    assign cols_used = (32'(cols_cfg_reg) > ssr_pkg::MAX_COLS) ? ssr_pkg::COLS_CAP : cols_cfg_reg;

    // register writes, unknown indexes fall through untouched
    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssr_pkg::REG_ROWS:
                begin
                    rows_cfg_next = cfg_data;
                end
                ssr_pkg::REG_COLS:
                begin
                    cols_cfg_next = cfg_data;
                end
                default:
                begin
                    rows_cfg_next = rows_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ssr_pkg::ROWS_RESET;
            cols_cfg_reg <= ssr_pkg::COLS_RESET;
        end
        else
        begin
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
        end
    end

    // classify each accepted beat into a fill, a read or a no-op
    ssr_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .rows_used (rows_used),
        .cols_used (cols_used),
        .q_stat    (q_stat),
        .b_stat    (b_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decouples acceptance from the span walker
    ssr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // canvas store, span walker and output register
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows_used (rows_used),
        .cols_used (cols_used),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .b_stat    (b_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* rtl/core/ssr_checker.sv */
// port-level checker of the shape span rasterizer and its bind
`default_nettype none

`include "shape_span_rasterizer_top_assert.svh"

module ssr_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire ssr_pkg::out_t                  out_data
);

    // a stalled result beat holds
    `SSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // no character comes back in a result that is out of bounds
    `SSR_ASSERT_NOW(a_oob_no_char, out_valid && !out_data.in_bounds, out_data.read_char == '0)

    // an in-bounds result is a pixel (one cell) or a read (none)
    `SSR_ASSERT_NOW(a_inb_count, out_valid && out_data.in_bounds, (out_data.pixels_written == '0) || (out_data.pixels_written == 13'd1))

    // a command that wrote cells returns no character
    `SSR_ASSERT_NOW(a_write_no_char, out_valid && (out_data.pixels_written != '0), out_data.read_char == '0)

endmodule

bind shape_span_rasterizer_top ssr_checker u_ssr_checker (.*);

`default_nettype wire

/* bench/ssr_canvas_checker.sv */
// checker for the shape span rasterizer: shadow canvas, result prediction and beat comparison
module ssr_canvas_checker
    import ssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_t                  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_t                 out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [USED_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   backlog
);

    logic [CHAR_W-1:0] canvas_shadow [CANVAS_DEPTH];
    logic [USED_W-1:0] rows_reg;
    logic [USED_W-1:0] cols_reg;
    out_t              awaited_results [$];
    out_t              want;
    int                errs;

    function automatic int live_rows();
        return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int live_cols();
        return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic bit on_canvas(input int x, input int y);
        return x >= 0 && y >= 0 && x < live_cols() && y < live_rows();
    endfunction

    // one clipped row of a shape, returns the cells painted
    function automatic int paint_span(input int row, input int xl, input int xr,
                                      input logic [CHAR_W-1:0] ch);
        int n;
        int c;
        n = 0;
        if (row < 0 || row >= live_rows())
            return 0;
        if (xl < 0)
            xl = 0;
        if (xr > live_cols() - 1)
            xr = live_cols() - 1;
        for (c = xl; c <= xr; c++)
        begin
            canvas_shadow[row * MAX_COLS + c] = ch;
            n++;
        end
        return n;
    endfunction

    function automatic out_t rasterize_cmd(input in_t cmd);
        out_t res;
        int   x;
        int   y;
        int   h;
        int   w;
        int   i;
        int   hw;
        int   half;
        int   cnt;
        res  = '0;
        cnt  = 0;
        x    = $signed(cmd.x_pos);
        y    = $signed(cmd.y_pos);
        h    = cmd.shape_height;
        w    = cmd.shape_width;
        half = h / 2;
        case (cmd.func)
            FN_CLEAR:
                for (i = 0; i < live_rows(); i++)
                    cnt += paint_span(i, 0, live_cols() - 1, DOT_CHAR);
            FN_PIXEL:
                if (on_canvas(x, y))
                begin
                    canvas_shadow[y * MAX_COLS + x] = cmd.brush_char;
                    res.in_bounds = 1'b1;
                    cnt = 1;
                end
            FN_RECT:
                if (w > 0)
                    for (i = 0; i < h; i++)
                        cnt += paint_span(y + i, x, x + w - 1, cmd.brush_char);
            FN_UP:
                for (i = 0; i < h; i++)
                    cnt += paint_span(y + i, x - i, x + i, cmd.brush_char);
            FN_DOWN:
                for (i = 0; i < h; i++)
                    cnt += paint_span(y - i, x - i, x + i, cmd.brush_char);
            FN_DIAMOND:
                for (i = 0; i < h; i++)
                begin
                    hw = 2 * half - i;
                    if (i < hw)
                        hw = i;
                    cnt += paint_span(y + i, x - hw, x + hw, cmd.brush_char);
                end
            FN_READ:
                if (on_canvas(x, y))
                begin
                    res.in_bounds = 1'b1;
                    res.read_char = canvas_shadow[y * MAX_COLS + x];
                end
            default:
                ;
        endcase
        res.pixels_written = cnt[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CANVAS_DEPTH; k++)
                canvas_shadow[k] = DOT_CHAR;
            rows_reg = ROWS_RESET;
            cols_reg = COLS_RESET;
            awaited_results.delete();
            errs = 0;
            mismatches <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                case (cfg_index)
                    REG_ROWS: rows_reg = cfg_data;
                    REG_COLS: cols_reg = cfg_data;
                    default:  ;
                endcase

            // a result beat never belongs to a command taken at the same edge
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no command awaiting it: %h", out_data);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.in_bounds !== want.in_bounds)
                    begin
                        $error("in_bounds mismatch: expected %0d, actual %0d",
                               want.in_bounds, out_data.in_bounds);
                        errs++;
                    end
                    if (out_data.read_char !== want.read_char)
                    begin
                        $error("read_char mismatch: expected %h, actual %h",
                               want.read_char, out_data.read_char);
                        errs++;
                    end
                    if (out_data.pixels_written !== want.pixels_written)
                    begin
                        $error("pixels_written mismatch: expected %0d, actual %0d",
                               want.pixels_written, out_data.pixels_written);
                        errs++;
                    end
                end
            end

            if (in_valid === 1'b1 && in_stall === 1'b0)
                awaited_results.push_back(rasterize_cmd(in_data));

            mismatches <= errs;
            backlog    <= awaited_results.size();
        end
    end

endmodule

/* bench/tb_shape_span_rasterizer_top.sv */
// testbench top of the shape span rasterizer: stimulus, handshake idling and verdict
module tb_shape_span_rasterizer_top;
    import ssr_pkg::*;

    // func 7 has no command behind it
    localparam logic [FUNC_W-1:0]    FN_SPARE    = 3'd7;
    // register indexes with nothing behind them, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // watchdog limit on the whole run, in cycles
    localparam int CYCLE_LIMIT = 4000000;
    // long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 400;
    // settling time after the last result, longer than a small command takes
    localparam int TAIL_CYCLES = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [USED_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int cycles;

    // flags shared between stimulus and receiver
    logic calm_tail    = 1'b0;
    logic hold_request = 1'b0;

    // canvas size in use, as the stimulus aims its coordinates
    int rows_now = 64;
    int cols_now = 64;

    shape_span_rasterizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts and compares
    ssr_canvas_checker canvas_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (fail_count),
        .backlog    (pending)
    );

    initial clk = 1'b0;

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // command building
    // ---------------------------------------------------------------

    function automatic in_t make_cmd(input logic [FUNC_W-1:0] fn, input int x, input int y,
                                     input int h, input int w, input int ch);
        in_t c;
        c.func         = fn;
        c.x_pos        = COORD_W'(x);
        c.y_pos        = COORD_W'(y);
        c.shape_height = HGT_W'(h);
        c.shape_width  = HGT_W'(w);
        c.brush_char   = CHAR_W'(ch);
        return c;
    endfunction

    // mostly well-aimed commands with small shapes, a few large ones and some raw noise
    function automatic in_t random_cmd();
        in_t         c;
        logic [63:0] raw;
        int          pick;
        int          span_r;
        int          span_c;
        int          x;
        int          y;
        int          h;
        int          w;
        int          ch;
        pick   = $urandom_range(0, 99);
        span_r = (rows_now > 0) ? rows_now : 1;
        span_c = (cols_now > 0) ? cols_now : 1;
        // a margin of a few cells round the canvas exercises the clipping
        x  = int'($urandom_range(0, span_c + 11)) - 6;
        y  = int'($urandom_range(0, span_r + 11)) - 6;
        h  = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 127))
                                          : int'($urandom_range(0, 9));
        w  = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 127))
                                          : int'($urandom_range(0, 9));
        ch = $urandom_range(0, 255);
        if (pick < 2)
            c = make_cmd(FN_CLEAR, x, y, h, w, ch);
        else if (pick < 16)
            c = make_cmd(FN_PIXEL, x, y, h, w, ch);
        else if (pick < 28)
            c = make_cmd(FN_RECT, x, y, h, w, ch);
        else if (pick < 38)
            c = make_cmd(FN_UP, x, y, h, w, ch);
        else if (pick < 48)
            c = make_cmd(FN_DOWN, x, y, h, w, ch);
        else if (pick < 58)
            c = make_cmd(FN_DIAMOND, x, y, h, w, ch);
        else if (pick < 90)
        begin
            // reads mostly land on the canvas so that painted cells get looked at
            if ($urandom_range(0, 4) != 0)
            begin
                x = $urandom_range(0, span_c - 1);
                y = $urandom_range(0, span_r - 1);
            end
            c = make_cmd(FN_READ, x, y, h, w, ch);
        end
        else if (pick < 92)
            c = make_cmd(FN_SPARE, x, y, h, w, ch);
        else
        begin
            // every field anywhere in its range, mostly far off the canvas
            raw = {$urandom(), $urandom()};
            c   = raw[$bits(in_t)-1:0];
        end
        return c;
    endfunction

    // ---------------------------------------------------------------
    // channel driving
    // ---------------------------------------------------------------

    // offers one command beat and returns at the edge that takes it;
    // valid is left high so the next beat can follow with no bubble
    task automatic send_cmd(input in_t cmd);
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // stops offering beats and waits until every awaited result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // config beat, valid stays high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [USED_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
    endtask

    // only called with the block idle
    task automatic set_canvas(input int rows, input int cols, input bit poke_spare);
        write_reg(REG_ROWS, USED_W'(rows));
        write_reg(REG_COLS, USED_W'(cols));
        if (poke_spare)
        begin
            // writes to unmapped indexes must leave the canvas size alone
            write_reg(REG_SPARE_A, USED_W'($urandom_range(0, 127)));
            write_reg(REG_SPARE_B, USED_W'($urandom_range(0, 127)));
        end
        cfg_valid <= 1'b0;
        rows_now = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        cols_now = (cols > MAX_COLS) ? MAX_COLS : cols;
    endtask

    // ---------------------------------------------------------------
    // receiver: random stall bursts, open stretches, one long hold-off
    // ---------------------------------------------------------------

    initial
    begin : receiver
        int stretch;
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                // results back up, the queue fills and the input side stalls
                out_stall <= 1'b1;
                stretch   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                stretch   = $urandom_range(1, 14);
            end
            else
            begin
                out_stall <= 1'b0;
                stretch   = $urandom_range(1, 24);
            end
            repeat (stretch - 1) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("shape_span_rasterizer_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus and verdict
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        int p;
        int k;
        int n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // the store sweep after reset holds the input side off; wait it out
        do
            @(posedge clk);
        while (in_stall !== 1'b1);
        do
            @(posedge clk);
        while (in_stall !== 1'b0);

        set_canvas(64, 64, 1'b1);

        // directed commands on the full 64 x 64 canvas
        send_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0));               // untouched cell is a dot
        send_cmd(make_cmd(FN_PIXEL, 0, 0, 127, 127, 8'hFF));
        send_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FN_PIXEL, 63, 63, 0, 0, 8'h00));        // far corner
        send_cmd(make_cmd(FN_READ, 63, 63, 127, 127, 8'hFF));
        send_cmd(make_cmd(FN_PIXEL, 64, 0, 1, 1, 8'h41));         // one past the right edge
        send_cmd(make_cmd(FN_PIXEL, -1, 5, 1, 1, 8'h42));         // negative column
        send_cmd(make_cmd(FN_READ, -2048, 2047, 0, 0, 0));
        send_cmd(make_cmd(FN_READ, 2047, -2048, 0, 0, 0));
        send_cmd(make_cmd(FN_RECT, -3, 60, 127, 127, 8'h52));     // clipped left, right, bottom
        send_cmd(make_cmd(FN_RECT, 5, 5, 6, 0, 8'h30));           // zero width
        send_cmd(make_cmd(FN_RECT, 5, 5, 0, 6, 8'h31));           // zero height
        send_cmd(make_cmd(FN_UP, 10, 2, 5, 0, 8'h55));
        send_cmd(make_cmd(FN_READ, 14, 6, 0, 0, 0));              // right end of the base row
        send_cmd(make_cmd(FN_DOWN, 50, 10, 6, 0, 8'h44));
        send_cmd(make_cmd(FN_READ, 45, 5, 0, 0, 0));              // left end of the top row
        send_cmd(make_cmd(FN_DIAMOND, 30, 20, 7, 0, 8'h4D));      // odd height
        send_cmd(make_cmd(FN_DIAMOND, 40, 30, 6, 0, 8'h6D));      // even height
        send_cmd(make_cmd(FN_DIAMOND, 30, 20, 0, 0, 8'h21));      // empty shape
        send_cmd(make_cmd(FN_READ, 33, 23, 0, 0, 0));             // widest row of the diamond
        send_cmd(make_cmd(FN_SPARE, 12, 12, 3, 3, 8'h7A));        // unused command
        send_cmd(make_cmd(FN_UP, 2047, 2047, 127, 127, 8'hFF));   // wholly off the canvas
        send_cmd(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0));

        // random phases, each under its own canvas size
        for (p = 0; p < 6; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    // oversized registers fall back to the store size
                    set_canvas(127, 127, 1'b0);
                    hold_request = 1'b1;
                    n = 220;
                end
                1:
                begin
                    set_canvas($urandom_range(1, 64), $urandom_range(1, 64), 1'b0);
                    n = 200;
                end
                2:
                begin
                    set_canvas(1, 64, 1'b1);
                    n = 150;
                end
                3:
                begin
                    set_canvas(64, 1, 1'b0);
                    n = 150;
                end
                4:
                begin
                    // no rows at all: every cell out of bounds, clear paints nothing
                    set_canvas(0, $urandom_range(0, 127), 1'b1);
                    n = 100;
                end
                default:
                begin
                    // closing stretch with neither side idling
                    set_canvas($urandom_range(1, 64), $urandom_range(1, 64), 1'b0);
                    calm_tail = 1'b1;
                    n = 430;
                end
            endcase
            for (k = 0; k < n; k++)
            begin
                // sender holds back once until every result is in
                if (p == 1 && k == n / 2)
                    drain_results();
                send_cmd(random_cmd());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("shape_span_rasterizer_top regression: pass");
        else
            $display("shape_span_rasterizer_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ssr_pkg.sv
rtl/core/ssr_front.sv
rtl/core/ssr_fifo.sv
rtl/core/ssr_back.sv
rtl/core/shape_span_rasterizer_top.sv
rtl/core/ssr_checker.sv
bench/ssr_canvas_checker.sv
bench/tb_shape_span_rasterizer_top.sv
